/* rtl/core/fwls_pkg.sv */
// ============================================================================
// fwls_pkg: shared types and constants of the flux-weighted light sampler
// Holds the input mode codes, result status codes, fixed-point widths and
// the one-hot state encoding used by the sampler control.
// ============================================================================
package fwls_pkg;

    // Fixed-point widths of the stream fields.
    localparam int FRAC_BITS   = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int INDEX_OUT_W = 8;
    localparam int PROB_W      = FRAC_BITS + 1;
    localparam int IN_WEIGHT_W = 32;

    // Packed beat widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // Probability of one in Q1.16.
    localparam logic [PROB_W-1:0]    PROB_ONE = PROB_W'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

    // Input mode codes carried in tuser.
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

    // Result status codes carried in tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_LIGHTS = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_IGNORED   = 2'd3
    } status_t;

    // Control sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_WALK = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

/* rtl/core/flux_weighted_light_sampler_top.sv */
// ============================================================================
// flux_weighted_light_sampler_top: light table with weighted sampling
// Stores light weights in a RAM with their running total and picks a light
// with probability proportional to its weight.
// ============================================================================
// Usage:
// Input beats on s_axis carry a mode in tuser: clear, append or sample.
// Every input beat produces exactly one result beat on m_axis, in order.
// include_virtual is written through cfg_valid/cfg_data, by the user only
// while idle; the block does not enforce it (cfg_ready is always high).
// Clear and append go from acceptance through ST_DONE to the result register.
// A sample runs ST_MUL and then the walk over the stored weights, which
// reads one weight per cycle from the single read port of the weight RAM;
// then, unless the picked weight is zero, two 17-step shift-subtract
// dividers run in parallel for the rescaled fraction and the probability.
// s_axis_tready is high only while the sequencer is idle, so one item is in
// work at a time. A finished result sits in the output register; the next
// item is accepted while it waits, and that item's result is held until
// the receiver takes the earlier one.
// Reset empties the table (count and total go to zero), clears
// include_virtual and drops any pending result. The RAM is not cleared.
// ============================================================================
module flux_weighted_light_sampler_top #(
    parameter int MAX_LIGHTS  = 256,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_data,     // [0] include_virtual
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] weight, [32] is_virtual, [48:33] random_fraction, [55:49] zero
    input  logic [fwls_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [fwls_pkg::MODE_W-1:0]       s_axis_tuser, // [1:0] mode
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] light_index, [23:8] rescaled_fraction, [40:24] probability,
    // [47:41] zero
    output logic [fwls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [fwls_pkg::STATUS_W-1:0]     m_axis_tuser  // [1:0] status
);
    import fwls_pkg::*;

    localparam int IDX_W   = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int COUNT_W = $clog2(MAX_LIGHTS + 1);
    localparam int TOTAL_W = WEIGHT_BITS + $clog2(MAX_LIGHTS);
    localparam int PROD_W  = TOTAL_W + FRAC_BITS;

    // Input beat fields.
    logic [WEIGHT_BITS-1:0] in_weight;
    logic                   in_virtual;
    logic [FRAC_BITS-1:0]   in_rnd;
    logic [MODE_W-1:0]      in_mode;

    assign in_weight  = WEIGHT_BITS'(s_axis_tdata[IN_WEIGHT_W-1:0]);
    assign in_virtual = s_axis_tdata[IN_WEIGHT_W];
    assign in_rnd     = s_axis_tdata[IN_WEIGHT_W+FRAC_BITS:IN_WEIGHT_W+1];
    assign in_mode    = s_axis_tuser;

    // Control state.
    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   incl_reg, incl_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   m_valid_reg, m_valid_next;

    // Datapath state.
    logic [FRAC_BITS-1:0]   rnd_reg, rnd_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [COUNT_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [TOTAL_W-1:0]     cum_reg, cum_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [TOTAL_W-1:0]     base_reg, base_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic                   frac_div_reg, frac_div_next;
    logic [FRAC_BITS-1:0]   frac_fix_reg, frac_fix_next;
    logic [INDEX_OUT_W-1:0] res_idx_reg, res_idx_next;
    logic [FRAC_BITS-1:0]   res_frac_reg, res_frac_next;
    logic [PROB_W-1:0]      res_prob_reg, res_prob_next;
    status_t                res_status_reg, res_status_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [STATUS_W-1:0]    m_user_reg, m_user_next;

    // RAM and divider connections.
    logic                   ram_we;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    logic                   div_start;
    logic                   frac_done, prob_done;
    logic [PROB_W-1:0]      frac_q, prob_q;

    // Walk and interval arithmetic.
    logic [TOTAL_W-1:0]     cum_sum;
    logic                   walk_hit, walk_last;
    logic [TOTAL_W-1:0]     qh;
    logic [FRAC_BITS-1:0]   ql;
    logic [TOTAL_W-1:0]     qh_off;
    logic [FRAC_BITS-1:0]   frac_sat;
    logic [PROB_W-1:0]      prob_sat;

    // Weight table. Appends write only while idle and the walk reads only
    // during a sample, so a read never meets a write to the same entry.
    fwls_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_LIGHTS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_weight),
        .raddr (rd_addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Fraction divider: ((qh - base) * 2^16 + ql) / weight.
    fwls_div #(
        .DIV_W (WEIGHT_BITS)
    ) u_frac_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (qh_off[WEIGHT_BITS-1:0]),
        .divisor  (w_reg),
        .low_bits (ql),
        .done     (frac_done),
        .quotient (frac_q)
    );

    // Probability divider: weight * 2^16 / total.
    fwls_div #(
        .DIV_W (TOTAL_W)
    ) u_prob_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (TOTAL_W'(w_reg)),
        .divisor  (total_reg),
        .low_bits ('0),
        .done     (prob_done),
        .quotient (prob_q)
    );

    // The scaled target is prod = qh * 2^16 + ql. An entry is hit when its
    // cumulative sum times 2^16 reaches the target.
    assign cum_sum   = cum_reg + TOTAL_W'(ram_rdata);
    assign walk_hit  = (prod_reg <= {cum_sum, {FRAC_BITS{1'b0}}});
    assign walk_last = (COUNT_W'(rd_idx_reg) == count_reg - 1'b1);
    assign qh        = prod_reg[PROD_W-1:FRAC_BITS];
    assign ql        = prod_reg[FRAC_BITS-1:0];
    assign qh_off    = qh - base_reg;

    // Saturation of the divider results.
    assign frac_sat  = frac_q[FRAC_BITS] ? FRAC_MAX : frac_q[FRAC_BITS-1:0];
    assign prob_sat  = (prob_q > PROB_ONE) ? PROB_ONE : prob_q;

    // Sequencer and result formation.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        incl_next       = incl_reg;
        rd_vld_next     = rd_vld_reg;
        m_valid_next    = m_valid_reg;
        rnd_next        = rnd_reg;
        prod_next       = prod_reg;
        rd_addr_next    = rd_addr_reg;
        rd_idx_next     = rd_idx_reg;
        cum_next        = cum_reg;
        w_next          = w_reg;
        base_next       = base_reg;
        pick_next       = pick_reg;
        frac_div_next   = frac_div_reg;
        frac_fix_next   = frac_fix_reg;
        res_idx_next    = res_idx_reg;
        res_frac_next   = res_frac_reg;
        res_prob_next   = res_prob_reg;
        res_status_next = res_status_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;

        if (cfg_valid)
        begin
            incl_next = cfg_data[0];
        end

        // The result register empties when the receiver takes the beat.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_idx_next    = '0;
                    res_frac_next   = '0;
                    res_prob_next   = '0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                    unique case (in_mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            // The full check comes before the virtual check.
                            if (count_reg == COUNT_W'(MAX_LIGHTS))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else if (in_virtual && !incl_reg)
                            begin
                                res_status_next = STATUS_IGNORED;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                total_next   = total_reg + TOTAL_W'(in_weight);
                                res_idx_next = INDEX_OUT_W'(count_reg);
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        MODE_SAMPLE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_NO_LIGHTS;
                            end
                            else
                            begin
                                rnd_next   = in_rnd;
                                state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_IGNORED;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next    = PROD_W'(total_reg) * PROD_W'(rnd_reg);
                rd_addr_next = '0;
                rd_vld_next  = 1'b0;
                cum_next     = '0;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                // Issue one read per cycle; data returns in the next cycle.
                rd_addr_next = rd_addr_reg + 1'b1;
                rd_vld_next  = 1'b1;
                rd_idx_next  = rd_addr_reg[IDX_W-1:0];
                if (rd_vld_reg)
                begin
                    cum_next = cum_sum;
                    // Running past the end picks the last entry.
                    if (walk_hit || walk_last)
                    begin
                        w_next     = ram_rdata;
                        base_next  = cum_reg;
                        pick_next  = rd_idx_reg;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                res_idx_next    = INDEX_OUT_W'(pick_reg);
                res_status_next = STATUS_OK;
                // A zero total forces a zero weight, so one test covers both.
                if (w_reg == '0)
                begin
                    res_frac_next = '0;
                    res_prob_next = '0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    div_start     = 1'b1;
                    frac_div_next = 1'b0;
                    if (qh < base_reg)
                    begin
                        frac_fix_next = '0;
                    end
                    else if (qh_off >= TOTAL_W'(w_reg))
                    begin
                        frac_fix_next = FRAC_MAX;
                    end
                    else
                    begin
                        frac_div_next = 1'b1;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (frac_done && prob_done)
                begin
                    res_frac_next = frac_div_reg ? frac_sat : frac_fix_reg;
                    res_prob_next = prob_sat;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(OUT_DATA_W - INDEX_OUT_W - FRAC_BITS - PROB_W){1'b0}},
                                    res_prob_reg, res_frac_reg, res_idx_reg};
                    m_user_next  = res_status_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            incl_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            incl_reg    <= incl_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rnd_reg        <= rnd_next;
        prod_reg       <= prod_next;
        rd_addr_reg    <= rd_addr_next;
        rd_idx_reg     <= rd_idx_next;
        cum_reg        <= cum_next;
        w_reg          <= w_next;
        base_reg       <= base_next;
        pick_reg       <= pick_next;
        frac_div_reg   <= frac_div_next;
        frac_fix_reg   <= frac_fix_next;
        res_idx_reg    <= res_idx_next;
        res_frac_reg   <= res_frac_next;
        res_prob_reg   <= res_prob_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    // Port drive.
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // The light count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_LIGHTS))
        else $error("light count exceeds table depth");

    // An accepted beat always takes the sequencer out of idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer stayed idle after accepting a beat");

    // The walk only consumes entries that hold a stored weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && rd_vld_reg) |-> (COUNT_W'(rd_idx_reg) < count_reg))
        else $error("walk read beyond the stored lights");

    // A delivered probability never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[INDEX_OUT_W+FRAC_BITS+PROB_W-1:INDEX_OUT_W+FRAC_BITS]
                         <= PROB_ONE))
        else $error("probability above one");

endmodule

/* rtl/core/fwls_ram.sv */
// ============================================================================
// fwls_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered so that
// a read returns in the cycle after its address is presented.
// ============================================================================
module fwls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/fwls_div.sv */
// ============================================================================
// fwls_div: restoring shift-subtract divider
// Produces a FRAC_BITS+1 bit quotient, one bit per cycle. The first step
// compares the initial remainder as it is; each later step shifts in one
// bit of low_bits. The initial remainder must be below twice the divisor.
// ============================================================================
module fwls_div #(
    parameter int DIV_W = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [DIV_W-1:0]                rem_init,
    input  logic [DIV_W-1:0]                divisor,
    input  logic [fwls_pkg::FRAC_BITS-1:0]  low_bits,
    output logic                            done,
    output logic [fwls_pkg::FRAC_BITS:0]    quotient
);
    import fwls_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [FRAC_BITS-1:0] low_reg, low_next;
    logic [FRAC_BITS:0]   quo_reg, quo_next;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // One trial subtraction per cycle.
    assign trial = (cnt_reg == '0) ? {1'b0, rem_reg}
                                   : {rem_reg, low_reg[FRAC_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Step sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = rem_init;
            dvs_next  = divisor;
            low_next  = low_bits;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[FRAC_BITS-1:0], fits};
            if (cnt_reg != '0)
            begin
                low_next = {low_reg[FRAC_BITS-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(FRAC_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
